### rtl/hvn_pkg.sv
// Constants shared by the hashed value noise block, its checker and its testbench.
package hvn_pkg;

   localparam int unsigned FRAC_BITS_DEF = 3;
   localparam int unsigned FRAC_BITS_MIN = 1;
   localparam int unsigned FRAC_BITS_MAX = 8;

   localparam int unsigned COORD_W  = 32;
   localparam int unsigned SEED_W   = 32;
   localparam int unsigned HASH_W   = 32;
   localparam int unsigned CORNER_W = 10;
   localparam int unsigned NOISE_W  = 16;
   localparam int unsigned CORNERS  = 4;

   localparam logic [HASH_W-1:0] HASH_MUL_X   = 32'd374761393;
   localparam logic [HASH_W-1:0] HASH_MUL_Z   = 32'd668265263;
   localparam logic [HASH_W-1:0] HASH_MUL_MIX = 32'd1274126177;

   localparam int unsigned MIX_SHIFT_1 = 13;
   localparam int unsigned MIX_SHIFT_2 = 16;

   localparam logic [NOISE_W-1:0] NOISE_SAT = 16'hFFFF;
   localparam logic [CORNER_W-1:0] CORNER_MAX = 10'd1023;

endpackage

### rtl/hashed_value_noise_2d.sv
// Top level: pipelined 2D hashed value noise with bilinear blend.
//
// Usage:
//   csr_wr_en / csr_wr_data load the 32-bit noise seed; write it only while
//   the pipeline is empty. Reset sets the seed to zero.
//   req_valid / req_ready carry one item: a signed (req_coord_x, req_coord_z)
//   lattice coordinate. rsp_valid / rsp_ready carry the matching
//   rsp_noise_value, in request order, one result per item.
//   Each item passes every register stage from acceptance to rsp_valid. Throughput
//   is one item per cycle while the receiver takes results; the two 32x32 hash
//   multiplies (coordinate scale, final mix) each own a register stage, and those set the clock period.
//   Each stage holds its item while the next one is full, so when the
//   receiver stalls, bubbles are squeezed out first and up to five items
//   are held; req_ready drops only once every stage is occupied.
//   Synchronous active-high reset empties the pipeline (all valid bits low).
//   Results above 16 bits (FRAC_BITS above 3) saturate at 65535.
module hashed_value_noise_2d #(
   parameter int unsigned FRAC_BITS = hvn_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [hvn_pkg::SEED_W-1:0]         csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [hvn_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [hvn_pkg::COORD_W-1:0] req_coord_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [hvn_pkg::NOISE_W-1:0]        rsp_noise_value
);

   localparam int unsigned HW    = hvn_pkg::HASH_W;
   localparam int unsigned CW    = hvn_pkg::CORNER_W;
   localparam int unsigned NC    = hvn_pkg::CORNERS;
   localparam int unsigned WT_W  = 2 * FRAC_BITS + 2;
   localparam int unsigned PRD_W = CW + WT_W;
   localparam int unsigned SUM_W = PRD_W + 2;
   localparam int unsigned CMP_W = (SUM_W > hvn_pkg::NOISE_W) ? SUM_W
                                                             : hvn_pkg::NOISE_W;

   // seed register
   logic [hvn_pkg::SEED_W-1:0] seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   // per-stage valid bits and ready chain
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;

   assign s5_rdy    = !s5_vld_ff || rsp_ready;
   assign s4_rdy    = !s4_vld_ff || s5_rdy;
   assign s3_rdy    = !s3_vld_ff || s4_rdy;
   assign s2_rdy    = !s2_vld_ff || s3_rdy;
   assign s1_rdy    = !s1_vld_ff || s2_rdy;
   assign req_ready = s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_vld_ff <= req_valid;
         if (s2_rdy) s2_vld_ff <= s1_vld_ff;
         if (s3_rdy) s3_vld_ff <= s2_vld_ff;
         if (s4_rdy) s4_vld_ff <= s3_vld_ff;
         if (s5_rdy) s5_vld_ff <= s4_vld_ff;
      end
   end

   // stage 1: cell index (floor), fractions, coordinate multiplies
   logic [HW-1:0]        cell_x, cell_z;
   logic [HW-1:0]        mul_x_in, mul_z_in, mul_x_ff, mul_z_ff;
   logic [FRAC_BITS-1:0] frac_x_in, frac_z_in, frac_x_ff, frac_z_ff;

   always_comb begin
      cell_x    = HW'(req_coord_x >>> FRAC_BITS);
      cell_z    = HW'(req_coord_z >>> FRAC_BITS);
      mul_x_in  = cell_x * hvn_pkg::HASH_MUL_X;
      mul_z_in  = cell_z * hvn_pkg::HASH_MUL_Z;
      frac_x_in = req_coord_x[FRAC_BITS-1:0];
      frac_z_in = req_coord_z[FRAC_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         mul_x_ff  <= mul_x_in;
         mul_z_ff  <= mul_z_in;
         frac_x_ff <= frac_x_in;
         frac_z_ff <= frac_z_in;
      end
   end

   // stage 2: x0+1 / z0+1 terms by adding the multiplier, seed xor, first mix;
   // bilinear weights
   logic [HW-1:0]      mul_x1, mul_z1;
   logic [HW-1:0]      pre_h  [NC];
   logic [HW-1:0]      mix_in [NC];
   logic [HW-1:0]      mix_ff [NC];
   logic [FRAC_BITS:0] wx [2];
   logic [FRAC_BITS:0] wz [2];
   logic [WT_W-1:0]    wt_in [NC];
   logic [WT_W-1:0]    wt2_ff [NC];

   always_comb begin
      mul_x1 = mul_x_ff + hvn_pkg::HASH_MUL_X;
      mul_z1 = mul_z_ff + hvn_pkg::HASH_MUL_Z;
      wx[0]  = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac_x_ff};
      wx[1]  = {1'b0, frac_x_ff};
      wz[0]  = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac_z_ff};
      wz[1]  = {1'b0, frac_z_ff};
      // corner i: bit 0 picks x0/x1, bit 1 picks z0/z1
      for (int i = 0; i < NC; i++) begin
         pre_h[i]  = seed_ff ^ ((i % 2 == 1) ? mul_x1 : mul_x_ff)
                             ^ ((i / 2 == 1) ? mul_z1 : mul_z_ff);
         mix_in[i] = pre_h[i] ^ (pre_h[i] >> hvn_pkg::MIX_SHIFT_1);
         wt_in[i]  = WT_W'(wx[i % 2]) * WT_W'(wz[i / 2]);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         for (int i = 0; i < NC; i++) begin
            mix_ff[i] <= mix_in[i];
            wt2_ff[i] <= wt_in[i];
         end
      end
   end

   // stage 3: final hash multiply
   logic [HW-1:0]   hash_in [NC];
   logic [HW-1:0]   hash_ff [NC];
   logic [WT_W-1:0] wt3_ff  [NC];

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         hash_in[i] = mix_ff[i] * hvn_pkg::HASH_MUL_MIX;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         for (int i = 0; i < NC; i++) begin
            hash_ff[i] <= hash_in[i];
            wt3_ff[i]  <= wt2_ff[i];
         end
      end
   end

   // stage 4: fold, keep low corner bits, weight each corner
   logic [HW-1:0]    fold    [NC];
   logic [CW-1:0]    corner  [NC];
   logic [PRD_W-1:0] prod_in [NC];
   logic [PRD_W-1:0] prod_ff [NC];

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         fold[i]    = hash_ff[i] ^ (hash_ff[i] >> hvn_pkg::MIX_SHIFT_2);
         corner[i]  = fold[i][CW-1:0];
         prod_in[i] = PRD_W'(corner[i]) * PRD_W'(wt3_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (s4_rdy) begin
         for (int i = 0; i < NC; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
   end

   // stage 5: sum and saturate into the output register
   logic [SUM_W-1:0]            sum;
   logic [CMP_W-1:0]            sum_ext;
   logic [hvn_pkg::NOISE_W-1:0] noise_in, noise_ff;

   always_comb begin
      sum = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1])
          + SUM_W'(prod_ff[2]) + SUM_W'(prod_ff[3]);
      sum_ext = CMP_W'(sum);
      if (sum_ext > CMP_W'(hvn_pkg::NOISE_SAT)) begin
         noise_in = hvn_pkg::NOISE_SAT;
      end else begin
         noise_in = sum_ext[hvn_pkg::NOISE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s5_rdy) begin
         noise_ff <= noise_in;
      end
   end

   assign rsp_valid       = s5_vld_ff;
   assign rsp_noise_value = noise_ff;

endmodule

### rtl/hvn_checker.sv
// Port-level checker for the hashed value noise block, with its bind.
module hvn_checker #(
   parameter int unsigned FRAC_BITS = hvn_pkg::FRAC_BITS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [hvn_pkg::NOISE_W-1:0] rsp_noise_value
);

   localparam logic [31:0] NOISE_MAX =
      (FRAC_BITS <= 3) ? (32'(hvn_pkg::CORNER_MAX) << (2 * FRAC_BITS))
                       : 32'(hvn_pkg::NOISE_SAT);

   // pipeline is empty the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // with no result pending every stage can move, so input is ready
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input not ready with output empty");

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_noise_value))
      else $error("stalled result changed");

   // blended value never exceeds the top corner value times the weight sum
   a_noise_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_noise_value) <= NOISE_MAX))
      else $error("noise value out of range");

endmodule

bind hashed_value_noise_2d hvn_checker #(
   .FRAC_BITS(FRAC_BITS)
) u_hvn_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_noise_value (rsp_noise_value)
);

### tb/sv/hashed_value_noise_2d_test.sv
// Self-checking testbench for the 2D hashed value noise block.
`timescale 1ns / 1ps

module hashed_value_noise_2d_test;

   localparam int unsigned FRAC       = hvn_pkg::FRAC_BITS_DEF;
   localparam int unsigned LATENCY    = 5;
   localparam int unsigned CYCLE_CAP  = 200000;
   localparam int unsigned PHASES     = 5;
   localparam int unsigned PHASE_LEN  = 180;
   localparam int unsigned STEADY_LEN = 100;

   logic                               clock;
   logic                               reset;
   logic                               csr_wr_en;
   logic [hvn_pkg::SEED_W-1:0]         csr_wr_data;
   logic                               req_valid;
   logic                               req_ready;
   logic signed [hvn_pkg::COORD_W-1:0] req_coord_x;
   logic signed [hvn_pkg::COORD_W-1:0] req_coord_z;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [hvn_pkg::NOISE_W-1:0]        rsp_noise_value;

   logic [hvn_pkg::NOISE_W-1:0]        expected_noise[$];
   logic [hvn_pkg::SEED_W-1:0]         seed_shadow;
   bit                                 idling_on;
   int unsigned                        mismatches;
   int unsigned                        items_sent;
   int unsigned                        results_seen;
   int unsigned                        seed_writes;
   int unsigned                        cycle_count;
   logic [hvn_pkg::COORD_W-1:0]        last_x;
   logic [hvn_pkg::COORD_W-1:0]        last_z;

   hashed_value_noise_2d #(.FRAC_BITS(FRAC)) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_coord_x     (req_coord_x),
      .req_coord_z     (req_coord_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_noise_value (rsp_noise_value)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // 10-bit lattice value of one cell corner
   function automatic logic [hvn_pkg::CORNER_W-1:0] corner_hash(
         logic [hvn_pkg::HASH_W-1:0] cx,
         logic [hvn_pkg::HASH_W-1:0] cz,
         logic [hvn_pkg::SEED_W-1:0] seed);
      logic [hvn_pkg::HASH_W-1:0] h;
      logic [hvn_pkg::HASH_W-1:0] px;
      logic [hvn_pkg::HASH_W-1:0] pz;
      px = cx * hvn_pkg::HASH_MUL_X;
      pz = cz * hvn_pkg::HASH_MUL_Z;
      h  = seed ^ px ^ pz;
      h  = (h ^ (h >> hvn_pkg::MIX_SHIFT_1)) * hvn_pkg::HASH_MUL_MIX;
      h  = h ^ (h >> hvn_pkg::MIX_SHIFT_2);
      return h[hvn_pkg::CORNER_W-1:0];
   endfunction

   function automatic logic [hvn_pkg::NOISE_W-1:0] blend_noise(
         logic [hvn_pkg::COORD_W-1:0] ux,
         logic [hvn_pkg::COORD_W-1:0] uz,
         logic [hvn_pkg::SEED_W-1:0] seed);
      logic [hvn_pkg::HASH_W-1:0] x0;
      logic [hvn_pkg::HASH_W-1:0] z0;
      logic [hvn_pkg::HASH_W-1:0] x1;
      logic [hvn_pkg::HASH_W-1:0] z1;
      longint unsigned   fx;
      longint unsigned   fz;
      longint unsigned   span;
      longint unsigned   ca, cb, cc, cd;
      longint unsigned   total;
      span = longint'(1) << FRAC;
      // floor division: arithmetic shift of the signed coordinate
      x0 = $signed(ux) >>> FRAC;
      z0 = $signed(uz) >>> FRAC;
      x1 = x0 + 1;
      z1 = z0 + 1;
      fx = ux & (span - 1);
      fz = uz & (span - 1);
      ca = corner_hash(x0, z0, seed);
      cb = corner_hash(x1, z0, seed);
      cc = corner_hash(x0, z1, seed);
      cd = corner_hash(x1, z1, seed);
      total = ca * (span - fx) * (span - fz) + cb * fx * (span - fz)
            + cc * (span - fx) * fz + cd * fx * fz;
      if (total > 64'hFFFF) total = 64'hFFFF;
      return total[hvn_pkg::NOISE_W-1:0];
   endfunction

   function automatic logic [hvn_pkg::COORD_W-1:0] pick_coord(
         logic [hvn_pkg::COORD_W-1:0] prev);
      logic [hvn_pkg::COORD_W-1:0] v;
      case ($urandom_range(0, 5))
         0:       v = $urandom_range(0, 63) - 32;
         1:       v = 32'h7FFF_FFC0 + $urandom_range(0, 63);
         2:       v = 32'h8000_0000 + $urandom_range(0, 63);
         3:       v = prev + $urandom_range(0, 16) - 8;   // neighbouring cells
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // runs from a falling edge and returns on the falling edge after acceptance
   task automatic send_coord(logic [hvn_pkg::COORD_W-1:0] x,
                             logic [hvn_pkg::COORD_W-1:0] z);
      int unsigned gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_coord_x <= x;
      req_coord_z <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_noise.push_back(blend_noise(x, z, seed_shadow));
      items_sent++;
      last_x = x;
      last_z = z;
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_noise.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_seed(logic [hvn_pkg::SEED_W-1:0] seed);
      drain_pipeline();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= seed;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      seed_shadow = seed;
      seed_writes++;
   endtask

   // reset seed; coordinate extremes, both signs, every fraction corner
   task automatic test_directed_corners();
      send_coord(32'd0, 32'd0);
      send_coord(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_coord(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_coord(32'h8000_0000, 32'h8000_0000);
      send_coord(32'h7FFF_FFFF, 32'h8000_0000);
      send_coord(32'h8000_0000, 32'h7FFF_FFFF);
      send_coord(32'd7, 32'd0);
      send_coord(32'd0, 32'd7);
      send_coord(32'd7, 32'd7);
      send_coord(32'd8, -32'sd8);
      send_coord(-32'sd9, 32'd3);
      send_coord(32'd5, -32'sd3);
   endtask

   task automatic test_seed_extremes();
      load_seed(32'hFFFF_FFFF);
      send_coord(32'd0, 32'd0);
      send_coord(32'h8000_0000, 32'h7FFF_FFFF);
      send_coord(32'd3, 32'd5);
      load_seed(32'h8000_0000);
      send_coord(-32'sd1, 32'd4);
      send_coord(32'h7FFF_FFF8, 32'h8000_0007);
      load_seed(32'd0);
      send_coord(32'd12, -32'sd12);
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < PHASES; p++) begin
         load_seed($urandom);
         for (int i = 0; i < PHASE_LEN; i++)
            send_coord(pick_coord(last_x), pick_coord(last_z));
      end
   endtask

   // back-to-back items with the receiver always ready
   task automatic test_steady_stream();
      load_seed($urandom);
      idling_on = 1'b0;
      for (int i = 0; i < STEADY_LEN; i++)
         send_coord(pick_coord(last_x), pick_coord(last_z));
      req_valid <= 1'b0;
   endtask

   // receiver stalls in bursts
   initial begin
      int unsigned stall_left;
      logic        ready_next;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   always @(posedge clock) begin
      logic [hvn_pkg::NOISE_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_noise.size() == 0) begin
            $error("noise_value: item with nothing expected, actual %0d", rsp_noise_value);
            mismatches++;
         end else begin
            want = expected_noise.pop_front();
            if (rsp_noise_value !== want) begin
               $error("noise_value mismatch: expected %0d, actual %0d", want,
                      rsp_noise_value);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_valid    = 1'b0;
      req_coord_x  = '0;
      req_coord_z  = '0;
      seed_shadow  = '0;
      idling_on    = 1'b1;
      mismatches   = 0;
      items_sent   = 0;
      results_seen = 0;
      seed_writes  = 0;
      cycle_count  = 0;
      last_x       = '0;
      last_z       = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_corners();
      test_seed_extremes();
      test_random_phases();
      test_steady_stream();

      while (expected_noise.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (expected_noise.size() != 0) begin
         $error("noise_value: %0d results never arrived", expected_noise.size());
         mismatches++;
      end

      $display("%0d coordinates sent, %0d results checked, %0d seed loads",
               items_sent, results_seen, seed_writes);
      $display("extremes, cell edges and random seeds covered; %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/hvn_pkg.sv
rtl/hashed_value_noise_2d.sv
rtl/hvn_checker.sv
tb/sv/hashed_value_noise_2d_test.sv
